// ===== src/refp_pkg.sv =====
// Shared constants and types for the ROI event frame parser.
package refp_pkg;

    // Frame layout: sync word, four region words, then the trailer words.
    localparam int TRAILER_WORDS = 5;
    localparam int HDR_LEN       = 5 + TRAILER_WORDS;
    localparam int STORE_DEPTH   = HDR_LEN - 1;
    localparam int IDX_W         = $clog2(STORE_DEPTH);
    localparam int CNT_W         = $clog2(STORE_DEPTH + 1);

    // With no trailer words the ymax word is the last header word and is never stored.
    localparam bit YMAX_STORED = (STORE_DEPTH > 4);
    localparam int YMAX_IDX    = YMAX_STORED ? 4 : 0;

    localparam int WORD_W   = 16;
    localparam int LIMIT_W  = 11;
    localparam int PIXCNT_W = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0]   SYNC_WORD = 16'hFFFF;
    localparam logic [LIMIT_W-1:0]  LIMIT_CAP = 11'd1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIXELS = 2'd2;

    localparam logic [LIMIT_W-1:0]  X_LIMIT_RST    = 11'd300;
    localparam logic [LIMIT_W-1:0]  Y_LIMIT_RST    = 11'd352;
    localparam logic [PIXCNT_W-1:0] MAX_PIXELS_RST = 21'd100000;

    // Result status codes.
    localparam logic [1:0] ST_EVENT    = 2'd0;
    localparam logic [1:0] ST_BAD_ROI  = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_PIXELS = 4'b0100,
        PH_SKIP   = 4'b1000
    } t_phase;

endpackage

// ===== src/refp_word_if.sv =====
// Input stream channel carrying one 16-bit detector word per transfer.
interface refp_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] in_word;

    modport source (output valid, output in_word, input ready);
    modport sink   (input valid, input in_word, output ready);
endinterface

// ===== src/refp_result_if.sv =====
// Result channel carrying event words and notices.
interface refp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_word;
    logic        first_of_event;
    logic        last_of_run;
    logic [1:0]  status;

    modport source (output valid, output out_word, output first_of_event,
                    output last_of_run, output status, input ready);
    modport sink   (input valid, input out_word, input first_of_event,
                    input last_of_run, input status, output ready);
endinterface

// ===== src/roi_event_frame_parser.sv =====
// Top level of the ROI event frame parser: deframing state machine and result register.
//
// Usage: detector words enter on i_in, one per transfer. Outside a frame every word
// other than the 0xFFFF sync word is dropped. A frame is the sync word, the four
// region words (xmin, xmax, ymin, ymax) and the trailer words, followed by the pixel
// words. The header is held inside until its last word arrives. A good event then
// leaves on o_out as the whole header (sync word flagged first_of_event) followed by
// every pixel word, the last one flagged last_of_run. A bad region or an oversized
// event gives a single notice word instead (zero data, last_of_run set, status code).
// Results are registered and reach o_out in the cycle after the transfer causing them.
// Throughput: one word per cycle, except that i_in is held not ready while the header
// is released through the result register. The result register lets a new word enter
// in the same cycle that the pending result is taken; when the receiver stalls, i_in
// drops ready and nothing is lost. Reset brings back the default limits, empties the
// result register and starts hunting for a sync word. The user must write limits
// through i_cfg_* only while the block is idle; the block does not enforce this.
module roi_event_frame_parser
    import refp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    refp_word_if.sink            i_in,
    refp_result_if.source        o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIXCNT_W-1:0]  i_cfg_data
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] XMAX_C  = CNT_W'(2);
    localparam logic [CNT_W-1:0] YMAX_C  = CNT_W'(4);

    // Configuration registers.
    logic [LIMIT_W-1:0]  r_x_limit;
    logic [LIMIT_W-1:0]  r_y_limit;
    logic [PIXCNT_W-1:0] r_max_pixels;

    // Parser state.
    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_hdr_cnt, n_hdr_cnt;
    logic [PIXCNT_W-1:0] r_pix_left, n_pix_left;
    logic [WORD_W-1:0]   r_store [STORE_DEPTH];
    logic [LIMIT_W-1:0]  r_dx, n_dx;
    logic [PIXCNT_W-1:0] r_npix, n_npix;

    // Header release sequencer.
    logic                r_rel_active, n_rel_active;
    logic [CNT_W-1:0]    r_rel_idx, n_rel_idx;
    logic [WORD_W-1:0]   r_last_hdr, n_last_hdr;

    // Result register.
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic                r_out_first;
    logic                r_out_last;
    logic [1:0]          r_out_status;

    logic                out_free;
    logic                in_fire;
    logic                load;
    logic [WORD_W-1:0]   ld_word;
    logic                ld_first;
    logic                ld_last;
    logic [1:0]          ld_status;
    logic                st_we;
    logic [IDX_W-1:0]    st_idx;

    logic [LIMIT_W-1:0]  c_xl, c_yl;
    logic [WORD_W-1:0]   c_xmin, c_xmax, c_ymin, c_ymax;
    logic                c_roi_ok;
    logic [LIMIT_W-1:0]  c_dy;
    logic [2*LIMIT_W-1:0] c_prod;
    logic [PIXCNT_W-1:0] c_npix;
    logic [WORD_W-1:0]   c_rel_word;

    // The result register frees up when it is empty or its word is taken this cycle.
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = out_free && !r_rel_active;
    assign in_fire    = i_in.valid && i_in.ready;

    // Region check on the stored header words, against limits capped at 1024.
    assign c_xl   = (r_x_limit > LIMIT_CAP) ? LIMIT_CAP : r_x_limit;
    assign c_yl   = (r_y_limit > LIMIT_CAP) ? LIMIT_CAP : r_y_limit;
    assign c_xmin = r_store[1];
    assign c_xmax = r_store[2];
    assign c_ymin = r_store[3];
    assign c_ymax = YMAX_STORED ? r_store[YMAX_IDX] : i_in.in_word;
    assign c_roi_ok = (c_xmax < WORD_W'(c_xl)) && (c_xmax > c_xmin)
                   && (c_ymax < WORD_W'(c_yl)) && (c_ymax > c_ymin);

    // The region widths only matter when the check passes, where they fit in 11 bits.
    // The product is taken as the ymax word passes and kept for the last header word.
    assign c_dy   = i_in.in_word[LIMIT_W-1:0] + LIMIT_W'(1) - r_store[3][LIMIT_W-1:0];
    assign c_prod = (2*LIMIT_W)'(r_dx) * (2*LIMIT_W)'(c_dy);
    assign c_npix = YMAX_STORED ? r_npix : c_prod[PIXCNT_W-1:0];

    assign c_rel_word = (r_rel_idx < DEPTH_C) ? r_store[r_rel_idx[IDX_W-1:0]] : r_last_hdr;

    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_pix_left   = r_pix_left;
        n_dx         = r_dx;
        n_npix       = r_npix;
        n_rel_active = r_rel_active;
        n_rel_idx    = r_rel_idx;
        n_last_hdr   = r_last_hdr;
        load         = 1'b0;
        ld_word      = '0;
        ld_first     = 1'b0;
        ld_last      = 1'b0;
        ld_status    = ST_EVENT;
        st_we        = 1'b0;
        st_idx       = '0;

        if (r_rel_active) begin
            // Release the held header one word per free slot; the last header word
            // was kept apart from the store.
            if (out_free) begin
                load      = 1'b1;
                ld_word   = c_rel_word;
                n_rel_idx = r_rel_idx + CNT_W'(1);
                if (r_rel_idx == DEPTH_C) begin
                    n_rel_active = 1'b0;
                end
            end
        end else if (in_fire) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_in.in_word == SYNC_WORD) begin
                        st_we     = 1'b1;
                        st_idx    = '0;
                        n_hdr_cnt = CNT_W'(1);
                        n_phase   = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (r_hdr_cnt < DEPTH_C) begin
                        st_we     = 1'b1;
                        st_idx    = r_hdr_cnt[IDX_W-1:0];
                        n_hdr_cnt = r_hdr_cnt + CNT_W'(1);
                        if (r_hdr_cnt == XMAX_C) begin
                            n_dx = i_in.in_word[LIMIT_W-1:0] + LIMIT_W'(1)
                                 - r_store[1][LIMIT_W-1:0];
                        end
                        if (r_hdr_cnt == YMAX_C) begin
                            n_npix = c_prod[PIXCNT_W-1:0];
                        end
                    end else begin
                        n_hdr_cnt = '0;
                        if (!c_roi_ok) begin
                            load      = 1'b1;
                            ld_last   = 1'b1;
                            ld_status = ST_BAD_ROI;
                            n_phase   = PH_HUNT;
                        end else begin
                            n_pix_left = c_npix;
                            if (c_npix > r_max_pixels) begin
                                load      = 1'b1;
                                ld_last   = 1'b1;
                                ld_status = ST_OVERSIZE;
                                n_phase   = PH_SKIP;
                            end else begin
                                // Sync word goes out now, the rest follows.
                                load         = 1'b1;
                                ld_word      = r_store[0];
                                ld_first     = 1'b1;
                                n_rel_active = 1'b1;
                                n_rel_idx    = CNT_W'(1);
                                n_last_hdr   = i_in.in_word;
                                n_phase      = PH_PIXELS;
                            end
                        end
                    end
                end
                PH_PIXELS: begin
                    load    = 1'b1;
                    ld_word = i_in.in_word;
                    if (r_pix_left <= PIXCNT_W'(1)) begin
                        ld_last    = 1'b1;
                        n_pix_left = '0;
                        n_phase    = PH_HUNT;
                    end else begin
                        n_pix_left = r_pix_left - PIXCNT_W'(1);
                    end
                end
                PH_SKIP: begin
                    // Pixel words of an oversized event are dropped without sync checks.
                    if (r_pix_left <= PIXCNT_W'(1)) begin
                        n_pix_left = '0;
                        n_phase    = PH_HUNT;
                    end else begin
                        n_pix_left = r_pix_left - PIXCNT_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit    <= X_LIMIT_RST;
            r_y_limit    <= Y_LIMIT_RST;
            r_max_pixels <= MAX_PIXELS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_X_LIMIT:    r_x_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_Y_LIMIT:    r_y_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_MAX_PIXELS: r_max_pixels <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_hdr_cnt    <= '0;
            r_pix_left   <= '0;
            r_rel_active <= 1'b0;
            r_rel_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_pix_left   <= n_pix_left;
            r_rel_active <= n_rel_active;
            r_rel_idx    <= n_rel_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_dx       <= n_dx;
        r_npix     <= n_npix;
        r_last_hdr <= n_last_hdr;
        if (st_we) begin
            r_store[st_idx] <= i_in.in_word;
        end
        if (load) begin
            r_out_word   <= ld_word;
            r_out_first  <= ld_first;
            r_out_last   <= ld_last;
            r_out_status <= ld_status;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_word       = r_out_word;
    assign o_out.first_of_event = r_out_first;
    assign o_out.last_of_run    = r_out_last;
    assign o_out.status         = r_out_status;

endmodule
